// ===== rtl/core/rvdec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM decoder package
// Shared types and constants for the instruction decoder: the dense
// instruction code, the split instruction fields and the packed result.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int unsigned InstrWidth  = 32;
  localparam int unsigned ResultWidth = 128;

  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_MISCMEM = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;

  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [11:0] IMM_ECALL  = 12'h000;
  localparam logic [11:0] IMM_EBREAK = 12'h001;

  typedef enum logic [5:0] {
    IC_LUI       = 6'd0,
    IC_AUIPC     = 6'd1,
    IC_JAL       = 6'd2,
    IC_JALR      = 6'd3,
    IC_BEQ       = 6'd4,
    IC_BNE       = 6'd5,
    IC_BLT       = 6'd6,
    IC_BGE       = 6'd7,
    IC_BLTU      = 6'd8,
    IC_BGEU      = 6'd9,
    IC_BRANCH_UK = 6'd10,
    IC_LB        = 6'd11,
    IC_LH        = 6'd12,
    IC_LW        = 6'd13,
    IC_LBU       = 6'd14,
    IC_LHU       = 6'd15,
    IC_LOAD_UK   = 6'd16,
    IC_SB        = 6'd17,
    IC_SH        = 6'd18,
    IC_SW        = 6'd19,
    IC_STORE_UK  = 6'd20,
    IC_ADDI      = 6'd21,
    IC_SLTI      = 6'd22,
    IC_SLTIU     = 6'd23,
    IC_XORI      = 6'd24,
    IC_ORI       = 6'd25,
    IC_ANDI      = 6'd26,
    IC_SLLI      = 6'd27,
    IC_SRLI      = 6'd28,
    IC_SRAI      = 6'd29,
    IC_MUL       = 6'd30,
    IC_MULH      = 6'd31,
    IC_MULHSU    = 6'd32,
    IC_MULHU     = 6'd33,
    IC_DIV       = 6'd34,
    IC_DIVU      = 6'd35,
    IC_REM       = 6'd36,
    IC_REMU      = 6'd37,
    IC_ADD       = 6'd38,
    IC_SUB       = 6'd39,
    IC_SLL       = 6'd40,
    IC_SLT       = 6'd41,
    IC_SLTU      = 6'd42,
    IC_XOR       = 6'd43,
    IC_SRL       = 6'd44,
    IC_SRA       = 6'd45,
    IC_OR        = 6'd46,
    IC_AND       = 6'd47,
    IC_FENCE     = 6'd48,
    IC_ECALL     = 6'd49,
    IC_EBREAK    = 6'd50,
    IC_SYSTEM    = 6'd51,
    IC_UNKNOWN   = 6'd52
  } instr_code_e;

  typedef struct packed {
    logic        [6:0]  opcode;
    logic        [4:0]  rd;
    logic        [2:0]  funct3;
    logic        [4:0]  rs1;
    logic        [4:0]  rs2;
    logic        [6:0]  funct7;
    logic signed [11:0] imm_i;
    logic signed [11:0] imm_s;
    logic signed [12:0] imm_b;
    logic        [31:0] imm_u;
    logic signed [20:0] imm_j;
  } fields_t;

  // Packed members run from the top bit down, so the first field of the
  // result (instr_code) lands in the highest bits of the stream word.
  typedef struct packed {
    instr_code_e        instr_code;
    logic signed [20:0] imm_jtype;
    logic        [31:0] imm_utype;
    logic signed [12:0] imm_btype;
    logic signed [11:0] imm_stype;
    logic signed [11:0] imm_itype;
    logic        [6:0]  upper_func;
    logic        [4:0]  src_reg_b;
    logic        [4:0]  src_reg_a;
    logic        [2:0]  minor_func;
    logic        [4:0]  dest_reg;
    logic        [6:0]  major_opcode;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/rvdec_fields.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM decoder field splitter
// Splits an instruction word into its register fields and assembles the
// I, S, B, U and J immediates.
// ----------------------------------------------------------------------------
module rvdec_fields (
  input  wire logic [rvdec_pkg::InstrWidth-1:0] instr_i,
  output rvdec_pkg::fields_t                    fields_o
);
  import rvdec_pkg::*;

  always_comb begin
    fields_o.opcode = instr_i[6:0];
    fields_o.rd     = instr_i[11:7];
    fields_o.funct3 = instr_i[14:12];
    fields_o.rs1    = instr_i[19:15];
    fields_o.rs2    = instr_i[24:20];
    fields_o.funct7 = instr_i[31:25];
    fields_o.imm_i  = instr_i[31:20];
    fields_o.imm_s  = {instr_i[31:25], instr_i[11:7]};
    fields_o.imm_b  = {instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
    fields_o.imm_u  = {instr_i[31:12], 12'h000};
    fields_o.imm_j  = {instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
  end

endmodule
`default_nettype wire

// ===== rtl/core/rvdec_class.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RV32IM decoder classifier
// Maps opcode, funct3, funct7 and the I immediate to the dense instruction
// code, with per-class unknown codes for unused funct3 values.
// ----------------------------------------------------------------------------
module rvdec_class (
  input  rvdec_pkg::fields_t     fields_i,
  output rvdec_pkg::instr_code_e code_o
);
  import rvdec_pkg::*;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_MB  = 3'd0;
  localparam logic [2:0] F3_MH  = 3'd1;
  localparam logic [2:0] F3_MW  = 3'd2;
  localparam logic [2:0] F3_MBU = 3'd4;
  localparam logic [2:0] F3_MHU = 3'd5;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  logic [2:0]  f3;
  logic        f7_alt;
  logic        f7_muldiv;
  logic [11:0] imm_i;

  assign f3        = fields_i.funct3;
  assign f7_alt    = (fields_i.funct7 == F7_ALT);
  assign f7_muldiv = (fields_i.funct7 == F7_MULDIV);
  assign imm_i     = fields_i.imm_i;

  always_comb begin
    code_o = IC_UNKNOWN;
    unique case (fields_i.opcode)
      OPC_LUI:     code_o = IC_LUI;
      OPC_AUIPC:   code_o = IC_AUIPC;
      OPC_JAL:     code_o = IC_JAL;
      OPC_JALR:    code_o = IC_JALR;
      OPC_BRANCH: begin
        unique case (f3)
          F3_BEQ:  code_o = IC_BEQ;
          F3_BNE:  code_o = IC_BNE;
          F3_BLT:  code_o = IC_BLT;
          F3_BGE:  code_o = IC_BGE;
          F3_BLTU: code_o = IC_BLTU;
          F3_BGEU: code_o = IC_BGEU;
          default: code_o = IC_BRANCH_UK;
        endcase
      end
      OPC_LOAD: begin
        unique case (f3)
          F3_MB:   code_o = IC_LB;
          F3_MH:   code_o = IC_LH;
          F3_MW:   code_o = IC_LW;
          F3_MBU:  code_o = IC_LBU;
          F3_MHU:  code_o = IC_LHU;
          default: code_o = IC_LOAD_UK;
        endcase
      end
      OPC_STORE: begin
        unique case (f3)
          F3_MB:   code_o = IC_SB;
          F3_MH:   code_o = IC_SH;
          F3_MW:   code_o = IC_SW;
          default: code_o = IC_STORE_UK;
        endcase
      end
      OPC_OPIMM: begin
        unique case (f3)
          F3_ADD:  code_o = IC_ADDI;
          F3_SLL:  code_o = IC_SLLI;
          F3_SLT:  code_o = IC_SLTI;
          F3_SLTU: code_o = IC_SLTIU;
          F3_XOR:  code_o = IC_XORI;
          F3_SR:   code_o = f7_alt ? IC_SRAI : IC_SRLI;
          F3_OR:   code_o = IC_ORI;
          F3_AND:  code_o = IC_ANDI;
          default: code_o = IC_UNKNOWN;
        endcase
      end
      OPC_OP: begin
        if (f7_muldiv) begin
          unique case (f3)
            F3_MUL:    code_o = IC_MUL;
            F3_MULH:   code_o = IC_MULH;
            F3_MULHSU: code_o = IC_MULHSU;
            F3_MULHU:  code_o = IC_MULHU;
            F3_DIV:    code_o = IC_DIV;
            F3_DIVU:   code_o = IC_DIVU;
            F3_REM:    code_o = IC_REM;
            F3_REMU:   code_o = IC_REMU;
            default:   code_o = IC_UNKNOWN;
          endcase
        end else begin
          unique case (f3)
            F3_ADD:  code_o = f7_alt ? IC_SUB : IC_ADD;
            F3_SLL:  code_o = IC_SLL;
            F3_SLT:  code_o = IC_SLT;
            F3_SLTU: code_o = IC_SLTU;
            F3_XOR:  code_o = IC_XOR;
            F3_SR:   code_o = f7_alt ? IC_SRA : IC_SRL;
            F3_OR:   code_o = IC_OR;
            F3_AND:  code_o = IC_AND;
            default: code_o = IC_UNKNOWN;
          endcase
        end
      end
      OPC_MISCMEM: code_o = IC_FENCE;
      OPC_SYSTEM: begin
        if (imm_i == IMM_ECALL) begin
          code_o = IC_ECALL;
        end else if (imm_i == IMM_EBREAK) begin
          code_o = IC_EBREAK;
        end else begin
          code_o = IC_SYSTEM;
        end
      end
      default:     code_o = IC_UNKNOWN;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/rv32im_instruction_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted word passes through the input register and then the result register before the result is offered.
// Throughput: one instruction per cycle; the input register and the result
// register advance together, so the input side stalls only while both hold
// an item and the result is not taken.
// Reset clears both valid flags; the payload registers are not reset.
// ----------------------------------------------------------------------------
// RV32IM instruction decoder
// Registers a 32-bit instruction word, splits its fields, builds the
// immediates and classifies it into a dense instruction code.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  // [31:0] instr_word
  input  wire logic [rvdec_pkg::InstrWidth-1:0]      s_axis_tdata,
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // [6:0] major_opcode, [11:7] dest_reg, [14:12] minor_func,
  // [19:15] src_reg_a, [24:20] src_reg_b, [31:25] upper_func,
  // [43:32] imm_itype, [55:44] imm_stype, [68:56] imm_btype,
  // [100:69] imm_utype, [121:101] imm_jtype, [127:122] instr_code
  output      logic [rvdec_pkg::ResultWidth-1:0]     m_axis_tdata
);
  import rvdec_pkg::*;

  logic                  in_vld_q;
  logic                  in_vld_d;
  logic [InstrWidth-1:0] in_word_q;
  logic                  out_vld_q;
  logic                  out_vld_d;
  result_t               out_q;
  result_t               out_d;
  logic                  advance;
  fields_t               fields;
  instr_code_e           code;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;
  assign out_vld_d     = advance ? in_vld_q : out_vld_q;

  rvdec_fields u_fields (
    .instr_i  (in_word_q),
    .fields_o (fields)
  );

  rvdec_class u_class (
    .fields_i (fields),
    .code_o   (code)
  );

  always_comb begin
    out_d.major_opcode = fields.opcode;
    out_d.dest_reg     = fields.rd;
    out_d.minor_func   = fields.funct3;
    out_d.src_reg_a    = fields.rs1;
    out_d.src_reg_b    = fields.rs2;
    out_d.upper_func   = fields.funct7;
    out_d.imm_itype    = fields.imm_i;
    out_d.imm_stype    = fields.imm_s;
    out_d.imm_btype    = fields.imm_b;
    out_d.imm_utype    = fields.imm_u;
    out_d.imm_jtype    = fields.imm_j;
    out_d.instr_code   = code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
    end
    if (advance && in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_accept_fills_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted transfer did not fill the input register");

  a_input_moves_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && advance |=> m_axis_tvalid)
    else $error("decoded item did not reach the result register");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled while the pipeline had room");

  a_code_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_q.instr_code <= IC_UNKNOWN)
    else $error("instruction code out of range");

  a_no_loss_on_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_q))
    else $error("pending result was overwritten");

endmodule
`default_nettype wire
